/* hdl/ssdiv_pkg.sv */
// Shared constants for the signed shift-subtract divider: sequencer state codes.
`default_nettype none

package ssdiv_pkg;

    localparam int STATE_W = 2;

    localparam logic [STATE_W-1:0] ST_IDLE   = 2'd0;
    localparam logic [STATE_W-1:0] ST_SETUP  = 2'd1;
    localparam logic [STATE_W-1:0] ST_DIVIDE = 2'd2;
    localparam logic [STATE_W-1:0] ST_FINISH = 2'd3;

endpackage

`default_nettype wire

/* hdl/signed_shift_subtract_divider.sv */
// Signed integer divider: restoring shift-subtract, one quotient bit per cycle.
//
// Channel  Direction  Handshake            Word
// -------  ---------  -------------------  ---------------------------------------
// input    in         in_valid / in_ready  numerator, denominator (signed)
// output   out        out_valid/out_ready  quotient (signed), div_by_zero, overflowed
//
// Steps: an accepted word passes through one setup step, DATA_WIDTH passes of the
//   shared subtractor and one finish step that loads the result. The next word is
//   taken only once the sequencer is back in idle, so words never overlap.
// Reset: rst_n clears the sequencer and the output valid flag; data registers are
//   left as they are.
// Stalls: in_ready is high only while the sequencer is idle. A result waiting in the
//   output register does not block the next word; only the finish step waits for it.
`default_nettype none

module signed_shift_subtract_divider #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         in_valid,
    output logic                        in_ready,
    input  wire  signed [DATA_WIDTH-1:0] numerator,
    input  wire  signed [DATA_WIDTH-1:0] denominator,
    output logic                        out_valid,
    input  wire                         out_ready,
    output logic signed [DATA_WIDTH-1:0] quotient,
    output logic                        div_by_zero,
    output logic                        overflowed
);

    localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);
    localparam logic [DATA_WIDTH-1:0] Q_ONE = DATA_WIDTH'(1);
    localparam logic [DATA_WIDTH-1:0] Q_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    // Sequencer
    logic [ssdiv_pkg::STATE_W-1:0] state_reg, state_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;

    // Operand capture and working registers
    logic [DATA_WIDTH-1:0] num_reg, num_next;
    logic [DATA_WIDTH-1:0] den_reg, den_next;
    logic [DATA_WIDTH-1:0] a_reg, a_next;     // dividend bits out, quotient bits in
    logic [DATA_WIDTH-1:0] b_reg, b_next;     // divisor magnitude
    logic [DATA_WIDTH-1:0] r_reg, r_next;     // partial remainder, below b when b is nonzero
    logic                  neg_reg, neg_next;
    logic                  eq_reg, eq_next;
    logic                  dz_reg, dz_next;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] quotient_reg, quotient_next;
    logic                  div_by_zero_reg, div_by_zero_next;
    logic                  overflowed_reg, overflowed_next;

    // Shared subtractor
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   diff;
    logic                  fits;
    logic                  in_accept;
    logic                  out_load;

    assign in_ready  = (state_reg == ssdiv_pkg::ST_IDLE);
    assign in_accept = in_valid && in_ready;

    // Shift in the next dividend bit and try the divisor against it.
    assign trial = {r_reg, a_reg[DATA_WIDTH-1]};
    assign diff  = trial - {1'b0, b_reg};
    assign fits  = !diff[DATA_WIDTH];

    // Finish loads the output only when the slot is free or being emptied.
    assign out_load = (state_reg == ssdiv_pkg::ST_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        num_next         = num_reg;
        den_next         = den_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        r_next           = r_reg;
        neg_next         = neg_reg;
        eq_next          = eq_reg;
        dz_next          = dz_reg;
        quotient_next    = quotient_reg;
        div_by_zero_next = div_by_zero_reg;
        overflowed_next  = overflowed_reg;

        unique case (state_reg)
            ssdiv_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    num_next   = numerator;
                    den_next   = denominator;
                    state_next = ssdiv_pkg::ST_SETUP;
                end
            end
            ssdiv_pkg::ST_SETUP:
            begin
                // Form magnitudes; the most negative value maps to 2^(W-1), which fits.
                eq_next  = (num_reg == den_reg);
                dz_next  = (den_reg == '0);
                neg_next = num_reg[DATA_WIDTH-1] ^ den_reg[DATA_WIDTH-1];
                a_next   = num_reg[DATA_WIDTH-1] ? (~num_reg + Q_ONE) : num_reg;
                b_next   = den_reg[DATA_WIDTH-1] ? (~den_reg + Q_ONE) : den_reg;
                r_next   = '0;
                cnt_next = CNT_LAST;
                state_next = ssdiv_pkg::ST_DIVIDE;
            end
            ssdiv_pkg::ST_DIVIDE:
            begin
                r_next = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
                a_next = {a_reg[DATA_WIDTH-2:0], fits};
                if (cnt_reg == '0)
                begin
                    state_next = ssdiv_pkg::ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ssdiv_pkg::ST_FINISH:
            begin
                if (out_load)
                begin
                    div_by_zero_next = 1'b0;
                    overflowed_next  = 1'b0;
                    priority if (eq_reg)
                    begin
                        // Equal operands, 0/0 included, give one.
                        quotient_next = Q_ONE;
                    end
                    else if (dz_reg)
                    begin
                        quotient_next    = '0;
                        div_by_zero_next = 1'b1;
                    end
                    else if (!neg_reg && a_reg[DATA_WIDTH-1])
                    begin
                        // Most negative over minus one: saturate.
                        quotient_next   = Q_MAX;
                        overflowed_next = 1'b1;
                    end
                    else if (neg_reg)
                    begin
                        quotient_next = ~a_reg + Q_ONE;
                    end
                    else
                    begin
                        quotient_next = a_reg;
                    end
                    state_next = ssdiv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssdiv_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssdiv_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg         <= num_next;
        den_reg         <= den_next;
        a_reg           <= a_next;
        b_reg           <= b_next;
        r_reg           <= r_next;
        neg_reg         <= neg_next;
        eq_reg          <= eq_next;
        dz_reg          <= dz_next;
        quotient_reg    <= quotient_next;
        div_by_zero_reg <= div_by_zero_next;
        overflowed_reg  <= overflowed_next;
    end

    assign out_valid   = out_valid_reg;
    assign quotient    = quotient_reg;
    assign div_by_zero = div_by_zero_reg;
    assign overflowed  = overflowed_reg;

`ifndef SYNTHESIS
    a_accept_to_setup: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ssdiv_pkg::ST_SETUP))
        else $error("accepted word did not start setup");

    a_last_bit_to_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssdiv_pkg::ST_DIVIDE && cnt_reg == '0)
        |=> (state_reg == ssdiv_pkg::ST_FINISH))
        else $error("divide loop did not end after the last bit");

    a_remainder_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssdiv_pkg::ST_DIVIDE && b_reg != '0) |-> (r_reg < b_reg))
        else $error("partial remainder reached the divisor");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(div_by_zero_reg && overflowed_reg))
        else $error("both result flags set");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid_reg && state_reg == ssdiv_pkg::ST_IDLE))
        else $error("finish step did not present a result");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for the signed shift-subtract divider, with a built-in quotient predictor.
`timescale 1ns / 100ps

module tb;

    localparam int W = 32;

    localparam logic [W-1:0] MOST_NEG  = 32'h8000_0000;
    localparam logic [W-1:0] MOST_POS  = 32'h7FFF_FFFF;
    localparam logic [W-1:0] MINUS_ONE = 32'hFFFF_FFFF;

    // Per-phase random word count; three phases after the directed table.
    localparam int RANDOM_PER_PHASE = 344;
    // Receiver hold-off, long enough to fill the output register and stall the input.
    localparam int LONG_HOLD_CYCLES = 400;
    // Drain time at the end, after the last awaited result has been seen.
    localparam int DRAIN_CYCLES     = 2 * (W + 3);
    // Watchdog limit in nanoseconds, well above the slowest legal run.
    localparam longint TIMEOUT_NS   = 64'd6_000_000;

    typedef struct packed {
        logic [W-1:0] quotient;
        logic         div_by_zero;
        logic         overflowed;
    } div_result_t;

    typedef struct packed {
        logic [W-1:0] numer;
        logic [W-1:0] denom;
        logic         typed;    // want holds a hand-written result
        div_result_t  want;
    } directed_row_t;

    localparam div_result_t NO_RESULT = '{32'h0, 1'b0, 1'b0};

    // Directed words: extremes, every special case, truncation toward zero.
    localparam int DIRECTED_ROWS = 23;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        // equal operands give one, zero over zero included
        '{32'h0,        32'h0,        1'b1, '{32'h1,          1'b0, 1'b0}},
        '{MOST_NEG,     MOST_NEG,     1'b1, '{32'h1,          1'b0, 1'b0}},
        '{MOST_POS,     MOST_POS,     1'b1, '{32'h1,          1'b0, 1'b0}},
        '{MINUS_ONE,    MINUS_ONE,    1'b1, '{32'h1,          1'b0, 1'b0}},
        // zero divisor with a nonzero dividend: flag, quotient zero
        '{32'h5,        32'h0,        1'b1, '{32'h0,          1'b1, 1'b0}},
        '{MINUS_ONE,    32'h0,        1'b1, '{32'h0,          1'b1, 1'b0}},
        '{MOST_NEG,     32'h0,        1'b1, '{32'h0,          1'b1, 1'b0}},
        '{MOST_POS,     32'h0,        1'b1, '{32'h0,          1'b1, 1'b0}},
        // most negative over minus one saturates; then other extremes and zero dividends
        '{MOST_NEG,     MINUS_ONE,    1'b1, '{MOST_POS,       1'b0, 1'b1}},
        '{MOST_POS,     32'h1,        1'b1, '{MOST_POS,       1'b0, 1'b0}},
        '{MOST_NEG,     32'h1,        1'b1, '{MOST_NEG,       1'b0, 1'b0}},
        '{MOST_POS,     MINUS_ONE,    1'b1, '{32'h8000_0001,  1'b0, 1'b0}},
        '{32'h0,        32'h5,        1'b1, '{32'h0,          1'b0, 1'b0}},
        '{32'h0,        MOST_NEG,     1'b1, '{32'h0,          1'b0, 1'b0}},
        '{32'h1,        MOST_NEG,     1'b1, '{32'h0,          1'b0, 1'b0}},
        // -7 / 2, 7 / -2, -7 / -2 truncate toward zero
        '{32'hFFFF_FFF9, 32'h2,       1'b1, '{32'hFFFF_FFFD,  1'b0, 1'b0}},
        '{32'h7,        32'hFFFF_FFFE, 1'b1, '{32'hFFFF_FFFD, 1'b0, 1'b0}},
        '{32'hFFFF_FFF9, 32'hFFFF_FFFE, 1'b1, '{32'h3,        1'b0, 1'b0}},
        '{32'd100,      32'd200,      1'b1, '{32'h0,          1'b0, 1'b0}},
        '{MOST_NEG,     MOST_POS,     1'b0, NO_RESULT},
        '{MOST_POS,     MOST_NEG,     1'b0, NO_RESULT},
        '{MOST_NEG,     32'h2,        1'b0, NO_RESULT},
        '{32'hAAAA_AAAA, 32'h3,       1'b0, NO_RESULT}
    };

    logic         clk         = 1'b0;
    logic         rst_n       = 1'b0;
    logic         in_valid    = 1'b0;
    logic         in_ready;
    logic [W-1:0] numerator   = '0;
    logic [W-1:0] denominator = '0;
    logic         out_valid;
    logic         out_ready   = 1'b0;
    logic [W-1:0] quotient;
    logic         div_by_zero;
    logic         overflowed;

    div_result_t  awaited_quotients[$];
    int           mismatch_count = 0;
    int           send_idle_pct  = 0;
    int           recv_idle_pct  = 0;
    bit           hold_request   = 1'b0;

    always #6 clk = ~clk;

    signed_shift_subtract_divider #(
        .DATA_WIDTH (W)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .numerator   (numerator),
        .denominator (denominator),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .quotient    (quotient),
        .div_by_zero (div_by_zero),
        .overflowed  (overflowed)
    );

    // Quotient predictor: restoring division on magnitudes one bit wider than the
    // operands, sign applied at the end, equal operands and zero divisors resolved up front.
    function automatic div_result_t expected_division(input logic [W-1:0] n,
                                                      input logic [W-1:0] d);
        div_result_t  res;
        logic [W:0]   mag_n;
        logic [W:0]   mag_d;
        logic [W:0]   rem;
        logic [W-1:0] q;
        logic         negate;
        res    = NO_RESULT;
        rem    = '0;
        q      = '0;
        negate = n[W-1] ^ d[W-1];
        mag_n  = {1'b0, n[W-1] ? (~n + 1'b1) : n};
        mag_d  = {1'b0, d[W-1] ? (~d + 1'b1) : d};
        if (n == d)
        begin
            res.quotient = 1;
            return res;
        end
        if (d == '0)
        begin
            res.div_by_zero = 1'b1;
            return res;
        end
        for (int i = W - 1; i >= 0; i--)
        begin
            rem = {rem[W-1:0], mag_n[i]};
            if (rem >= mag_d)
            begin
                rem  = rem - mag_d;
                q[i] = 1'b1;
            end
        end
        if (!negate && q[W-1])
        begin
            // only the most negative value over minus one lands here
            res.quotient   = MOST_POS;
            res.overflowed = 1'b1;
            return res;
        end
        res.quotient = negate ? (~q + 1'b1) : q;
        return res;
    endfunction

    // Operand mix: full-range words, small values, scaled magnitudes and extremes.
    function automatic logic [W-1:0] random_operand();
        logic [W-1:0] v;
        case ($urandom_range(7))
            0, 1, 2: v = $urandom;
            3:       v = $urandom_range(40) - 20;
            4, 5:
            begin
                v = $urandom >> $urandom_range(W - 1);
                if ($urandom_range(1) == 1)
                    v = ~v + 1'b1;
            end
            default:
            begin
                case ($urandom_range(4))
                    0:       v = MOST_NEG;
                    1:       v = MOST_POS;
                    2:       v = MINUS_ONE;
                    3:       v = 1;
                    default: v = '0;
                endcase
            end
        endcase
        return v;
    endfunction

    // Offer one word, idling at random first; record what it must produce once taken.
    task automatic send_word(input logic [W-1:0] n, input logic [W-1:0] d,
                             input div_result_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        numerator   <= n;
        denominator <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        awaited_quotients.insert(awaited_quotients.size(), want);
    endtask

    // Receiver: random back-pressure, plus one long hold-off when asked for.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                out_ready  <= 1'b0;
                stall_left = stall_left - 1;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD_CYCLES - 1;
                out_ready    <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Result checker: every word taken from the block must match the oldest expectation.
    always @(posedge clk)
    begin
        div_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_quotients.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word: quotient %0d dbz %b ovf %b",
                             $signed(quotient), div_by_zero, overflowed);
            end
            else
            begin
                want = awaited_quotients.pop_front();
                if (quotient !== want.quotient || div_by_zero !== want.div_by_zero
                    || overflowed !== want.overflowed)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: quotient %0d/%0d dbz %b/%b ovf %b/%b (exp/act)",
                                 $signed(want.quotient), $signed(quotient),
                                 want.div_by_zero, div_by_zero,
                                 want.overflowed, overflowed);
                end
            end
        end
    end

    // Stimulus: reset, directed table, then three random phases with shifting idle mixes.
    initial
    begin
        logic [W-1:0] n;
        logic [W-1:0] d;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender light, receiver heavy for the table and the first random phase
        send_idle_pct = 23;
        recv_idle_pct = 51;
        foreach (DIRECTED[i])
            send_word(DIRECTED[i].numer, DIRECTED[i].denom,
                      DIRECTED[i].typed ? DIRECTED[i].want
                                        : expected_division(DIRECTED[i].numer,
                                                            DIRECTED[i].denom));

        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                send_idle_pct = 51;
                recv_idle_pct = 23;
            end
            else if (phase == 2)
            begin
                // no idling; hold the output long enough to back up the input
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_request  = 1'b1;
            end
            repeat (RANDOM_PER_PHASE)
            begin
                n = random_operand();
                case ($urandom_range(15))
                    0:       d = n;                    // equal operands
                    1:       d = '0;                   // zero divisor
                    2:       d = MINUS_ONE;
                    3:       d = $urandom_range(1, 9);
                    default: d = random_operand();
                endcase
                send_word(n, d, expected_division(n, d));
            end
        end
        in_valid <= 1'b0;

        while (awaited_quotients.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: end the run as failing once the time limit is reached.
    initial
    begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
hdl/ssdiv_pkg.sv
hdl/signed_shift_subtract_divider.sv
tb/sv/tb.sv
